// ===== hdl/ljps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Leading jet pair selector package
// Shared constants and types for the leading jet pair selector.
// ----------------------------------------------------------------------------
package ljps_pkg;

    localparam int ETA_W    = 14;
    localparam int PHI_W    = 13;
    localparam int PT_W     = 16;
    localparam int SPREAD_W = 16;
    localparam int BETA_W   = 13;
    localparam int TAG_W    = 3;
    localparam int INDEX_W  = 8;
    localparam int RADIUS_W = 24;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 3;

    localparam logic [ETA_W-1:0] ETA_BARREL = 14'd1536;
    localparam logic [ETA_W-1:0] ETA_ENDCAP = 14'd4096;
    localparam logic [PHI_W:0]   PI_FX      = 14'd3217;
    localparam logic [PHI_W:0]   TWO_PI_FX  = 14'd6434;

    localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_BARREL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA_BARREL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_ENDCAP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA_ENDCAP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_RADIUS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VETO_MODE     = 3'd5;

    localparam logic VETO_OWN_PICKS = 1'b0;
    localparam logic KIND_JET       = 1'b0;

    typedef struct packed {
        logic [SPREAD_W-1:0] spread_max_barrel;
        logic [BETA_W-1:0]   beta_limit_barrel;
        logic [SPREAD_W-1:0] spread_max_endcap;
        logic [BETA_W-1:0]   beta_limit_endcap;
    } pileup_cfg_t;

endpackage

// ===== hdl/ljps_pileup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pileup check
// Passes a jet whose spread and beta lie below the limits of its eta region.
// ----------------------------------------------------------------------------
module ljps_pileup
(
    input  ljps_pkg::pileup_cfg_t              cfg,
    input  logic signed [ljps_pkg::ETA_W-1:0]  eta,
    input  logic [ljps_pkg::SPREAD_W-1:0]      mean_sq_spread,
    input  logic [ljps_pkg::BETA_W-1:0]        beta_star,
    output logic                               pass
);
    import ljps_pkg::*;

    logic [ETA_W-1:0] abs_eta;

    always_comb
    begin
        abs_eta = eta[ETA_W-1] ? (~eta + 1'b1) : eta;
        if (abs_eta < ETA_BARREL)
        begin
            pass = (mean_sq_spread < cfg.spread_max_barrel) &&
                   (beta_star < cfg.beta_limit_barrel);
        end
        else if (abs_eta < ETA_ENDCAP)
        begin
            pass = (mean_sq_spread < cfg.spread_max_endcap) &&
                   (beta_star < cfg.beta_limit_endcap);
        end
        else
        begin
            pass = 1'b0;
        end
    end

endmodule

// ===== hdl/ljps_overlap.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Overlap check
// Flags a jet whose squared eta-phi distance to a reference is under the
// squared match radius, with the phi difference wrapped at pi.
// ----------------------------------------------------------------------------
module ljps_overlap
(
    input  logic signed [ljps_pkg::ETA_W-1:0] eta_a,
    input  logic signed [ljps_pkg::PHI_W-1:0] phi_a,
    input  logic signed [ljps_pkg::ETA_W-1:0] eta_b,
    input  logic signed [ljps_pkg::PHI_W-1:0] phi_b,
    input  logic [ljps_pkg::RADIUS_W-1:0]     radius_sq,
    output logic                              hit
);
    import ljps_pkg::*;

    logic signed [ETA_W:0] d_eta;
    logic [ETA_W:0]        abs_deta;
    logic signed [PHI_W:0] d_phi;
    logic [PHI_W:0]        abs_dphi;
    logic [PHI_W:0]        wrap_dphi;
    logic [2*ETA_W+2:0]    dist_sq;

    always_comb
    begin
        d_eta    = {eta_a[ETA_W-1], eta_a} - {eta_b[ETA_W-1], eta_b};
        abs_deta = d_eta[ETA_W] ? (~d_eta + 1'b1) : d_eta;
        d_phi    = {phi_a[PHI_W-1], phi_a} - {phi_b[PHI_W-1], phi_b};
        abs_dphi = d_phi[PHI_W] ? (~d_phi + 1'b1) : d_phi;
        // One wrap step always lands within pi for 13-bit phi inputs.
        if (abs_dphi > PI_FX)
        begin
            wrap_dphi = (abs_dphi > TWO_PI_FX) ? (abs_dphi - TWO_PI_FX)
                                               : (TWO_PI_FX - abs_dphi);
        end
        else
        begin
            wrap_dphi = abs_dphi;
        end
        dist_sq = ((2*ETA_W+3)'(abs_deta) * (2*ETA_W+3)'(abs_deta)) +
                  ((2*ETA_W+3)'(wrap_dphi) * (2*ETA_W+3)'(wrap_dphi));
        hit = dist_sq < (2*ETA_W+3)'(radius_sq);
    end

endmodule

// ===== hdl/leading_jet_pair_selector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Leading jet pair selector
// Filters the jets of an event and keeps the two with the highest momentum,
// reporting both picks on the last jet of the event.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Word
//  in       input      in_valid/in_stall    one jet or one veto object load
//  out      output     out_valid/out_stall  both picks of one event
//  cfg      input      cfg_write            one limit or mode register
//
//  A word is registered on input and resolved from there; one word is taken
//  every cycle unless a last jet waits; results pass to the result register.
//  The per-event picks feed back into the veto check in own-picks mode.
//  Reset clears the picks, veto slots, position counter and valid flags.
//  A last jet waits in the input register while a held result is stalled.
// ----------------------------------------------------------------------------
module leading_jet_pair_selector
#(
    parameter int MAX_JETS = 256
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [ljps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ljps_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                kind,
    input  logic [ljps_pkg::PT_W-1:0]           pt,
    input  logic signed [ljps_pkg::ETA_W-1:0]   eta,
    input  logic signed [ljps_pkg::PHI_W-1:0]   phi,
    input  logic [ljps_pkg::SPREAD_W-1:0]       mean_sq_spread,
    input  logic [ljps_pkg::BETA_W-1:0]         beta_star,
    input  logic [ljps_pkg::TAG_W-1:0]          tag_value,
    input  logic                                veto_slot,
    input  logic                                last,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                lead_found,
    output logic [ljps_pkg::INDEX_W-1:0]        lead_index,
    output logic [ljps_pkg::TAG_W-1:0]          lead_tag,
    output logic                                second_found,
    output logic [ljps_pkg::INDEX_W-1:0]        second_index,
    output logic [ljps_pkg::TAG_W-1:0]          second_tag
);
    import ljps_pkg::*;

    localparam int POS_W = (MAX_JETS > 2) ? $clog2(MAX_JETS) : 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_JETS - 1);

    typedef struct packed {
        logic                    valid;
        logic [INDEX_W-1:0]      index;
        logic [TAG_W-1:0]        tag;
        logic [PT_W-1:0]         pt;
        logic signed [ETA_W-1:0] eta;
        logic signed [PHI_W-1:0] phi;
    } pick_t;

    pileup_cfg_t          pileup_cfg_reg;
    logic [RADIUS_W-1:0]  match_radius_sq_reg;
    logic                 veto_mode_reg;

    logic                    in_vld_reg;
    logic                    in_kind_reg;
    logic [PT_W-1:0]         in_pt_reg;
    logic signed [ETA_W-1:0] in_eta_reg;
    logic signed [PHI_W-1:0] in_phi_reg;
    logic [SPREAD_W-1:0]     in_spread_reg;
    logic [BETA_W-1:0]       in_beta_reg;
    logic [TAG_W-1:0]        in_tag_reg;
    logic                    in_slot_reg;
    logic                    in_last_reg;

    pick_t                   pick_reg [2];
    pick_t                   pick_next [2];
    logic                    veto_valid_reg [2];
    logic signed [ETA_W-1:0] veto_eta_reg [2];
    logic signed [PHI_W-1:0] veto_phi_reg [2];
    logic [POS_W-1:0]        pos_reg;
    logic [POS_W+INDEX_W-1:0] pos_ext;
    logic [INDEX_W-1:0]      jet_index;

    logic                    out_valid_reg;
    logic                    lead_found_reg;
    logic [INDEX_W-1:0]      lead_index_reg;
    logic [TAG_W-1:0]        lead_tag_reg;
    logic                    second_found_reg;
    logic [INDEX_W-1:0]      second_index_reg;
    logic [TAG_W-1:0]        second_tag_reg;

    logic                    ref_valid [2];
    logic signed [ETA_W-1:0] ref_eta [2];
    logic signed [PHI_W-1:0] ref_phi [2];
    logic                    ref_hit [2];
    logic                    pileup_pass;
    logic                    keep;
    logic                    is_jet;
    logic                    gives_result;
    logic                    out_free;
    logic                    advance;
    logic                    proc;
    logic                    in_take;

    ljps_pileup u_pileup
    (
        .cfg            (pileup_cfg_reg),
        .eta            (in_eta_reg),
        .mean_sq_spread (in_spread_reg),
        .beta_star      (in_beta_reg),
        .pass           (pileup_pass)
    );

    for (genvar g = 0; g < 2; g++)
    begin : g_veto
        always_comb
        begin
            if (veto_mode_reg == VETO_OWN_PICKS)
            begin
                ref_valid[g] = pick_reg[g].valid;
                ref_eta[g]   = pick_reg[g].eta;
                ref_phi[g]   = pick_reg[g].phi;
            end
            else
            begin
                ref_valid[g] = veto_valid_reg[g];
                ref_eta[g]   = veto_eta_reg[g];
                ref_phi[g]   = veto_phi_reg[g];
            end
        end

        ljps_overlap u_overlap
        (
            .eta_a     (in_eta_reg),
            .phi_a     (in_phi_reg),
            .eta_b     (ref_eta[g]),
            .phi_b     (ref_phi[g]),
            .radius_sq (match_radius_sq_reg),
            .hit       (ref_hit[g])
        );
    end

    assign is_jet       = (in_kind_reg == KIND_JET);
    assign gives_result = is_jet && in_last_reg;
    assign out_free     = !out_valid_reg || !out_stall;
    assign advance      = !gives_result || out_free;
    assign proc         = in_vld_reg && advance;
    assign in_stall     = in_vld_reg && !advance;
    assign in_take      = in_valid && !in_stall;

    assign keep = pileup_pass && (in_tag_reg != '0) &&
                  !(ref_valid[0] && ref_hit[0]) && !(ref_valid[1] && ref_hit[1]);

    assign pos_ext   = {{INDEX_W{1'b0}}, pos_reg};
    assign jet_index = pos_ext[INDEX_W-1:0];

    always_comb
    begin
        pick_t fresh;
        fresh.valid = 1'b1;
        fresh.index = jet_index;
        fresh.tag   = in_tag_reg;
        fresh.pt    = in_pt_reg;
        fresh.eta   = in_eta_reg;
        fresh.phi   = in_phi_reg;
        pick_next[0] = pick_reg[0];
        pick_next[1] = pick_reg[1];
        if (keep)
        begin
            if (!pick_reg[0].valid)
            begin
                pick_next[0] = fresh;
            end
            else if (in_pt_reg > pick_reg[0].pt)
            begin
                pick_next[1] = pick_reg[0];
                pick_next[0] = fresh;
            end
            else if (!pick_reg[1].valid || (in_pt_reg > pick_reg[1].pt))
            begin
                pick_next[1] = fresh;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pileup_cfg_reg.spread_max_barrel <= 16'd4588;
            pileup_cfg_reg.beta_limit_barrel <= 13'd3564;
            pileup_cfg_reg.spread_max_endcap <= 16'd4588;
            pileup_cfg_reg.beta_limit_endcap <= 13'd3482;
            match_radius_sq_reg              <= 24'd262144;
            veto_mode_reg                    <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SPREAD_BARREL: pileup_cfg_reg.spread_max_barrel <= cfg_data[SPREAD_W-1:0];
                CFG_BETA_BARREL:   pileup_cfg_reg.beta_limit_barrel <= cfg_data[BETA_W-1:0];
                CFG_SPREAD_ENDCAP: pileup_cfg_reg.spread_max_endcap <= cfg_data[SPREAD_W-1:0];
                CFG_BETA_ENDCAP:   pileup_cfg_reg.beta_limit_endcap <= cfg_data[BETA_W-1:0];
                CFG_MATCH_RADIUS:  match_radius_sq_reg <= cfg_data[RADIUS_W-1:0];
                CFG_VETO_MODE:     veto_mode_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (proc)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_kind_reg   <= kind;
            in_pt_reg     <= pt;
            in_eta_reg    <= eta;
            in_phi_reg    <= phi;
            in_spread_reg <= mean_sq_spread;
            in_beta_reg   <= beta_star;
            in_tag_reg    <= tag_value;
            in_slot_reg   <= veto_slot;
            in_last_reg   <= last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                pick_reg[i]       <= '0;
                veto_valid_reg[i] <= 1'b0;
                veto_eta_reg[i]   <= '0;
                veto_phi_reg[i]   <= '0;
            end
            pos_reg <= '0;
        end
        else if (proc)
        begin
            if (!is_jet)
            begin
                veto_valid_reg[in_slot_reg] <= 1'b1;
                veto_eta_reg[in_slot_reg]   <= in_eta_reg;
                veto_phi_reg[in_slot_reg]   <= in_phi_reg;
            end
            else if (in_last_reg)
            begin
                for (int i = 0; i < 2; i++)
                begin
                    pick_reg[i]       <= '0;
                    veto_valid_reg[i] <= 1'b0;
                    veto_eta_reg[i]   <= '0;
                    veto_phi_reg[i]   <= '0;
                end
                pos_reg <= '0;
            end
            else
            begin
                pick_reg[0] <= pick_next[0];
                pick_reg[1] <= pick_next[1];
                pos_reg     <= (pos_reg == POS_LAST) ? '0 : (pos_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc && gives_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc && gives_result)
        begin
            lead_found_reg   <= pick_next[0].valid;
            lead_index_reg   <= pick_next[0].valid ? pick_next[0].index : '0;
            lead_tag_reg     <= pick_next[0].valid ? pick_next[0].tag : '0;
            second_found_reg <= pick_next[1].valid;
            second_index_reg <= pick_next[1].valid ? pick_next[1].index : '0;
            second_tag_reg   <= pick_next[1].valid ? pick_next[1].tag : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign lead_found   = lead_found_reg;
    assign lead_index   = lead_index_reg;
    assign lead_tag     = lead_tag_reg;
    assign second_found = second_found_reg;
    assign second_index = second_index_reg;
    assign second_tag   = second_tag_reg;

endmodule

// ===== tb/ljps_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Leading jet pair selector scoreboard
// Tracks the per-event picks and veto objects of the selector from the words
// that it accepts, and checks each reported pair against the expected one.
// ----------------------------------------------------------------------------
package ljps_tb_pkg;

    import ljps_pkg::*;

    localparam logic KIND_LOAD   = 1'b1;
    localparam logic VETO_LOADED = 1'b1;
    localparam int   MAX_REPORTS = 10;

    typedef struct {
        logic                       kind;
        logic [PT_W-1:0]            pt;
        logic signed [ETA_W-1:0]    eta;
        logic signed [PHI_W-1:0]    phi;
        logic [SPREAD_W-1:0]        spread;
        logic [BETA_W-1:0]          beta;
        logic [TAG_W-1:0]           tag;
        logic                       veto_slot;
        logic                       last;
    } jet_word_t;

    typedef struct {
        logic                       lead_found;
        logic [INDEX_W-1:0]         lead_index;
        logic [TAG_W-1:0]           lead_tag;
        logic                       second_found;
        logic [INDEX_W-1:0]         second_index;
        logic [TAG_W-1:0]           second_tag;
    } pair_report_t;

    typedef struct {
        bit                         valid;
        logic [INDEX_W-1:0]         index;
        logic [TAG_W-1:0]           tag;
        logic [PT_W-1:0]            pt;
        int                         eta;
        int                         phi;
    } pick_t;

    class jet_pair_scoreboard;

        logic [SPREAD_W-1:0] spread_max_barrel;
        logic [BETA_W-1:0]   beta_limit_barrel;
        logic [SPREAD_W-1:0] spread_max_endcap;
        logic [BETA_W-1:0]   beta_limit_endcap;
        logic [RADIUS_W-1:0] match_radius_sq;
        logic                veto_mode;

        pick_t               picks[2];
        bit                  veto_valid[2];
        int                  veto_eta[2];
        int                  veto_phi[2];
        logic [INDEX_W-1:0]  position;

        pair_report_t        report_q[$];
        int                  errors;

        function new();
            spread_max_barrel = 16'd4588;
            beta_limit_barrel = 13'd3564;
            spread_max_endcap = 16'd4588;
            beta_limit_endcap = 13'd3482;
            match_radius_sq   = 24'd262144;
            veto_mode         = VETO_OWN_PICKS;
            errors            = 0;
            clear_event();
        endfunction

        function void clear_event();
            for (int i = 0; i < 2; i++)
            begin
                picks[i].valid = 1'b0;
                picks[i].index = '0;
                picks[i].tag   = '0;
                picks[i].pt    = '0;
                picks[i].eta   = 0;
                picks[i].phi   = 0;
                veto_valid[i]  = 1'b0;
                veto_eta[i]    = 0;
                veto_phi[i]    = 0;
            end
            position = '0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                CFG_SPREAD_BARREL: spread_max_barrel = value[SPREAD_W-1:0];
                CFG_BETA_BARREL:   beta_limit_barrel = value[BETA_W-1:0];
                CFG_SPREAD_ENDCAP: spread_max_endcap = value[SPREAD_W-1:0];
                CFG_BETA_ENDCAP:   beta_limit_endcap = value[BETA_W-1:0];
                CFG_MATCH_RADIUS:  match_radius_sq   = value[RADIUS_W-1:0];
                CFG_VETO_MODE:     veto_mode         = value[0];
                default: ;
            endcase
        endfunction

        function bit is_close(int eta_a, int phi_a, int eta_b, int phi_b);
            int     de;
            int     dp;
            longint dist_sq;
            de = eta_a - eta_b;
            dp = phi_a - phi_b;
            if (dp < 0)
                dp = -dp;
            while (dp > int'(PI_FX))
            begin
                dp = dp - int'(TWO_PI_FX);
                if (dp < 0)
                    dp = -dp;
            end
            dist_sq = longint'(de) * de + longint'(dp) * dp;
            return dist_sq < longint'(match_radius_sq);
        endfunction

        function bit pileup_rejects(int eta, logic [SPREAD_W-1:0] spread,
                                    logic [BETA_W-1:0] beta);
            int abs_eta;
            abs_eta = (eta < 0) ? -eta : eta;
            if (abs_eta < int'(ETA_BARREL))
                return !(spread < spread_max_barrel && beta < beta_limit_barrel);
            if (abs_eta < int'(ETA_ENDCAP))
                return !(spread < spread_max_endcap && beta < beta_limit_endcap);
            return 1'b1;
        endfunction

        function void note_word(jet_word_t w);
            int                 eta;
            int                 phi;
            bit                 keep;
            logic [INDEX_W-1:0] pos;
            pick_t              fresh;
            pair_report_t       r;
            eta = w.eta;
            phi = w.phi;
            if (w.kind == KIND_LOAD)
            begin
                veto_valid[w.veto_slot] = 1'b1;
                veto_eta[w.veto_slot]   = eta;
                veto_phi[w.veto_slot]   = phi;
                return;
            end
            pos      = position;
            position = position + 1'b1;
            keep = !pileup_rejects(eta, w.spread, w.beta) && (w.tag != '0);
            for (int i = 0; i < 2; i++)
            begin
                if (keep && veto_mode == VETO_OWN_PICKS)
                begin
                    if (picks[i].valid && is_close(eta, phi, picks[i].eta, picks[i].phi))
                        keep = 1'b0;
                end
                else if (keep)
                begin
                    if (veto_valid[i] && is_close(eta, phi, veto_eta[i], veto_phi[i]))
                        keep = 1'b0;
                end
            end
            if (keep)
            begin
                fresh.valid = 1'b1;
                fresh.index = pos;
                fresh.tag   = w.tag;
                fresh.pt    = w.pt;
                fresh.eta   = eta;
                fresh.phi   = phi;
                if (!picks[0].valid)
                    picks[0] = fresh;
                else if (w.pt > picks[0].pt)
                begin
                    picks[1] = picks[0];
                    picks[0] = fresh;
                end
                else if (!picks[1].valid || w.pt > picks[1].pt)
                    picks[1] = fresh;
            end
            if (w.last)
            begin
                r.lead_found   = picks[0].valid;
                r.lead_index   = picks[0].valid ? picks[0].index : '0;
                r.lead_tag     = picks[0].valid ? picks[0].tag : '0;
                r.second_found = picks[1].valid;
                r.second_index = picks[1].valid ? picks[1].index : '0;
                r.second_tag   = picks[1].valid ? picks[1].tag : '0;
                report_q.push_back(r);
                clear_event();
            end
        endfunction

        function int pending();
            return report_q.size();
        endfunction

        function void note_error(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("[%0t] ERROR: %s", $time, msg);
        endfunction

        function void compare(string name, int unsigned want, int unsigned got);
            if (want != got)
                note_error($sformatf("%s expected %0d, got %0d", name, want, got));
        endfunction

        function void check_result(pair_report_t got);
            pair_report_t want;
            if (report_q.size() == 0)
            begin
                note_error("pair reported with no event pending");
                return;
            end
            want = report_q.pop_front();
            compare("lead_found", want.lead_found, got.lead_found);
            compare("lead_index", want.lead_index, got.lead_index);
            compare("lead_tag", want.lead_tag, got.lead_tag);
            compare("second_found", want.second_found, got.second_found);
            compare("second_index", want.second_index, got.second_index);
            compare("second_tag", want.second_tag, got.second_tag);
        endfunction

        function void finish_check();
            if (report_q.size() != 0)
                note_error($sformatf("%0d pair reports never arrived", report_q.size()));
        endfunction

    endclass

endpackage

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Leading jet pair selector testbench
// Streams directed and random events of jets and veto loads through the
// selector under several limit and mode settings, with random idling on both
// channels, and checks every reported pair against the scoreboard.
// ----------------------------------------------------------------------------
module tb;

    import ljps_pkg::*;
    import ljps_tb_pkg::*;

    localparam int DRAIN_CYCLES = 6;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic                   kind = 1'b0;
    logic [PT_W-1:0]        pt = '0;
    logic signed [ETA_W-1:0] eta = '0;
    logic signed [PHI_W-1:0] phi = '0;
    logic [SPREAD_W-1:0]    mean_sq_spread = '0;
    logic [BETA_W-1:0]      beta_star = '0;
    logic [TAG_W-1:0]       tag_value = '0;
    logic                   veto_slot = 1'b0;
    logic                   last = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   lead_found;
    logic [INDEX_W-1:0]     lead_index;
    logic [TAG_W-1:0]       lead_tag;
    logic                   second_found;
    logic [INDEX_W-1:0]     second_index;
    logic [TAG_W-1:0]       second_tag;

    jet_pair_scoreboard     sb;
    bit                     calm = 1'b0;
    int                     jets_sent = 0;
    int                     anchor_eta = 0;
    int                     anchor_phi = 0;
    int unsigned            last_pt = 0;

    int unsigned            spread_barrel_lim = 4588;
    int unsigned            beta_barrel_lim = 3564;
    int unsigned            spread_endcap_lim = 4588;
    int unsigned            beta_endcap_lim = 3482;
    int unsigned            radius_lim = 262144;
    logic                   mode_sel = VETO_OWN_PICKS;

    leading_jet_pair_selector i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .pt             (pt),
        .eta            (eta),
        .phi            (phi),
        .mean_sq_spread (mean_sq_spread),
        .beta_star      (beta_star),
        .tag_value      (tag_value),
        .veto_slot      (veto_slot),
        .last           (last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .lead_found     (lead_found),
        .lead_index     (lead_index),
        .lead_tag       (lead_tag),
        .second_found   (second_found),
        .second_index   (second_index),
        .second_tag     (second_tag)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(0, 99) < 31);
    end

    always @(posedge clk)
    begin
        jet_word_t    seen_word;
        pair_report_t seen_pair;
        if (rst_n && in_valid && !in_stall)
        begin
            seen_word.kind      = kind;
            seen_word.pt        = pt;
            seen_word.eta       = eta;
            seen_word.phi       = phi;
            seen_word.spread    = mean_sq_spread;
            seen_word.beta      = beta_star;
            seen_word.tag       = tag_value;
            seen_word.veto_slot = veto_slot;
            seen_word.last      = last;
            sb.note_word(seen_word);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            seen_pair.lead_found   = lead_found;
            seen_pair.lead_index   = lead_index;
            seen_pair.lead_tag     = lead_tag;
            seen_pair.second_found = second_found;
            seen_pair.second_index = second_index;
            seen_pair.second_tag   = second_tag;
            sb.check_result(seen_pair);
        end
    end

    function automatic jet_word_t word_of(logic k, int p, int e, int f, int s, int b,
                                          int t, logic slot, logic is_last);
        jet_word_t w;
        w.kind      = k;
        w.pt        = PT_W'(p);
        w.eta       = ETA_W'(e);
        w.phi       = PHI_W'(f);
        w.spread    = SPREAD_W'(s);
        w.beta      = BETA_W'(b);
        w.tag       = TAG_W'(t);
        w.veto_slot = slot;
        w.last      = is_last;
        return w;
    endfunction

    function automatic int unsigned below(int unsigned lim);
        if (lim == 0 || $urandom_range(0, 99) < 10)
            return lim;
        return $urandom_range(0, lim - 1);
    endfunction

    function automatic jet_word_t random_jet(logic is_last);
        jet_word_t   w;
        int          e;
        int          f;
        int          abs_eta;
        int unsigned p;
        if ($urandom_range(0, 99) < 25)
            return word_of(KIND_JET, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom_range(0, 1), is_last);
        if ($urandom_range(0, 99) < 20)
        begin
            e = anchor_eta + $urandom_range(0, 1400) - 700;
            f = anchor_phi + $urandom_range(0, 1400) - 700;
        end
        else
        begin
            case ($urandom_range(0, 5))
                0:       abs_eta = $urandom_range(1530, 1541);
                1:       abs_eta = $urandom_range(4090, 4101);
                2, 3:    abs_eta = $urandom_range(0, 1535);
                default: abs_eta = $urandom_range(1536, 4095);
            endcase
            e = $urandom_range(0, 1) ? -abs_eta : abs_eta;
            if ($urandom_range(0, 99) < 10)
                f = $urandom_range(0, 1) ? -$urandom_range(3200, 3217) : $urandom_range(3200, 3217);
            else
                f = $urandom_range(0, 6434) - 3217;
        end
        abs_eta = (e < 0) ? -e : e;
        p = ($urandom_range(0, 99) < 10) ? last_pt : $urandom_range(0, 65535);
        last_pt = p;
        if ($urandom_range(0, 99) < 30)
        begin
            anchor_eta = e;
            anchor_phi = f;
        end
        if (abs_eta < 1536)
            w = word_of(KIND_JET, p, e, f, below(spread_barrel_lim), below(beta_barrel_lim),
                        $urandom_range(1, 7), $urandom_range(0, 1), is_last);
        else
            w = word_of(KIND_JET, p, e, f, below(spread_endcap_lim), below(beta_endcap_lim),
                        $urandom_range(1, 7), $urandom_range(0, 1), is_last);
        return w;
    endfunction

    function automatic jet_word_t random_load();
        jet_word_t w;
        w = word_of(KIND_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom_range(0, 1), $urandom_range(0, 1));
        if ($urandom_range(0, 99) < 60)
        begin
            anchor_eta = $urandom_range(0, 8191) - 4096;
            anchor_phi = $urandom_range(0, 6434) - 3217;
            w.eta = ETA_W'(anchor_eta);
            w.phi = PHI_W'(anchor_phi);
        end
        return w;
    endfunction

    task automatic send_word(jet_word_t w);
        while (!calm && $urandom_range(0, 99) < 31)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        kind           <= w.kind;
        pt             <= w.pt;
        eta            <= w.eta;
        phi            <= w.phi;
        mean_sq_spread <= w.spread;
        beta_star      <= w.beta;
        tag_value      <= w.tag;
        veto_slot      <= w.veto_slot;
        last           <= w.last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        @(posedge clk);
        sb.set_register(idx, CFG_W'(value));
    endtask

    task automatic program_registers();
        write_reg(CFG_SPREAD_BARREL, spread_barrel_lim);
        write_reg(CFG_BETA_BARREL, beta_barrel_lim);
        write_reg(CFG_SPREAD_ENDCAP, spread_endcap_lim);
        write_reg(CFG_BETA_ENDCAP, beta_endcap_lim);
        write_reg(CFG_MATCH_RADIUS, radius_lim);
        write_reg(CFG_VETO_MODE, mode_sel);
        cfg_write <= 1'b0;
    endtask

    task automatic run_event(int n_jets);
        int n_loads;
        n_loads = ($urandom_range(0, 99) < 60) ? $urandom_range(1, 2) : 0;
        repeat (n_loads) send_word(random_load());
        for (int j = 0; j < n_jets; j++)
        begin
            if ($urandom_range(0, 99) < 5)
                send_word(random_load());
            send_word(random_jet(j == n_jets - 1));
            jets_sent++;
        end
    endtask

    task automatic choose_settings(int phase);
        spread_barrel_lim = 4588;
        beta_barrel_lim   = 3564;
        spread_endcap_lim = 4588;
        beta_endcap_lim   = 3482;
        radius_lim        = 262144;
        mode_sel          = (phase == 1) ? VETO_LOADED : VETO_OWN_PICKS;
        if (phase == 2)
        begin
            spread_barrel_lim = 65535;
            beta_barrel_lim   = 4096;
            spread_endcap_lim = 65535;
            beta_endcap_lim   = 4096;
            radius_lim        = 16777215;
        end
        else if (phase == 3)
        begin
            spread_barrel_lim = 0;
            beta_barrel_lim   = 0;
            spread_endcap_lim = 0;
            beta_endcap_lim   = 0;
            radius_lim        = 0;
            mode_sel          = VETO_LOADED;
        end
        else if (phase == 5)
            radius_lim = $urandom_range(0, 4000000);
        else if (phase >= 4)
        begin
            spread_barrel_lim = $urandom_range(0, 65535);
            beta_barrel_lim   = $urandom_range(0, 4096);
            spread_endcap_lim = $urandom_range(0, 65535);
            beta_endcap_lim   = $urandom_range(0, 4096);
            radius_lim        = $urandom_range(0, 4000000);
            mode_sel          = $urandom_range(0, 1);
        end
    endtask

    initial
    begin
        int start;
        int target;
        int len;
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(word_of(KIND_JET, 100, 0, 0, 0, 0, 1, 0, 0));
        send_word(word_of(KIND_JET, 100, 2000, 1000, 0, 0, 2, 0, 0));
        send_word(word_of(KIND_JET, 200, -2000, -2000, 0, 0, 3, 0, 0));
        send_word(word_of(KIND_JET, 50, 100, 100, 0, 0, 4, 0, 0));
        send_word(word_of(KIND_JET, 65535, 3000, 0, 0, 0, 0, 0, 0));
        send_word(word_of(KIND_JET, 300, 1536, 3217, 4587, 3481, 5, 0, 1));
        send_word(word_of(KIND_JET, 900, -1535, 0, 4588, 0, 7, 0, 0));
        send_word(word_of(KIND_JET, 900, 4095, 0, 0, 3482, 7, 0, 0));
        send_word(word_of(KIND_JET, 900, 4096, 0, 0, 0, 7, 0, 0));
        send_word(word_of(KIND_JET, 900, -8192, -4096, 0, 0, 7, 0, 0));
        send_word(word_of(KIND_JET, 0, 0, 0, 0, 0, 7, 0, 1));
        send_word(word_of(KIND_JET, 500, 0, 0, 0, 0, 0, 0, 1));
        wait_idle();
        mode_sel = VETO_LOADED;
        program_registers();
        send_word(word_of(KIND_LOAD, 0, 0, 3200, 0, 0, 0, 0, 1));
        send_word(word_of(KIND_LOAD, 0, 5000, 0, 0, 0, 0, 1, 0));
        send_word(word_of(KIND_JET, 10, 0, -3200, 0, 0, 1, 0, 0));
        send_word(word_of(KIND_JET, 5, 300, 0, 0, 0, 2, 0, 0));
        send_word(word_of(KIND_JET, 6, 310, 10, 0, 0, 3, 0, 1));

        for (int phase = 0; phase < 8; phase++)
        begin
            wait_idle();
            choose_settings(phase);
            program_registers();
            calm   = (phase == 4);
            target = (phase == 3) ? 60 : 200;
            start  = jets_sent;
            if (phase == 5)
                run_event(270);
            while (jets_sent - start < target)
            begin
                len = ($urandom_range(0, 99) < 10) ? $urandom_range(9, 40) : $urandom_range(1, 8);
                run_event(len);
            end
        end

        wait_idle();
        sb.finish_check();
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
